@@ src/histogram_2d_binning_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the two-dimensional histogram block.
// Each macro takes a label, a condition and the property that must follow.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_2D_BINNING_ASSERT_SVH
`define HISTOGRAM_2D_BINNING_ASSERT_SVH

// The property holds in the same cycle as the condition.
`define H2D_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("histogram check failed");

// The property holds in the cycle after the condition.
`define H2D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("histogram check failed");

`endif

@@ src/hist2d_pkg.sv @@
// ----------------------------------------------------------------------------
// hist2d_pkg
// Types, codes and command/status bundles shared by the histogram modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hist2d_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_BAD_CFG = 2'd2;
    localparam logic [1:0] ST_BAD_IDX = 2'd3;

    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_X_LOWER = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_X_UPPER = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_LOWER = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_Y_UPPER = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BINS_X  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BINS_Y  = 3'd5;

    // Multiplier product: 32-bit offset times a 7-bit bin count.
    localparam int PROD_W = 39;
    localparam int BIN_W  = 7;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] sample_x;
        logic signed [31:0] sample_y;
        logic [5:0]         read_bin_x;
        logic [5:0]         read_bin_y;
    } hist2d_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] bin_count;
        logic [31:0] sample_total;
        logic [31:0] bin_fraction;
    } hist2d_rsp_t;

    typedef struct packed {
        logic       load_item;
        logic       sweep_start;
        logic       sweep_step;
        logic       clr_total;
        logic       inc_total;
        logic       mul_x;
        logic       go_x;
        logic       take_ix;
        logic       mul_y;
        logic       go_y;
        logic       take_iy;
        logic       take_ridx;
        logic       take_count;
        logic       write_inc;
        logic       go_frac;
        logic       load_result;
        logic [1:0] res_status;
        logic       show_total;
        logic       show_count;
    } hist2d_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       cfg_ok;
        logic       in_range;
        logic       idx_ok;
        logic       sweep_last;
        logic       div_done;
        logic       rsp_free;
    } hist2d_stat_t;

endpackage

`default_nettype wire

@@ src/histogram_2d_binning.sv @@
// ----------------------------------------------------------------------------
// histogram_2d_binning
// Two-dimensional histogram over uniform bins with clear, add and read words.
// ----------------------------------------------------------------------------
// Each request word is handled alone, from acceptance to result. An add that
// falls inside the rectangle runs two seven-step divisions for the bin
// indexes, a read-modify-write of the counter RAM and a 32-step division for
// the Q1.31 fraction, all on one shared bit-serial divider. A read of a valid
// bin runs the counter read and the fraction division; errors, samples
// outside the rectangle and the unused opcode skip these steps. A clear writes
// zero to every counter, one per cycle; the same clearing pass runs after
// reset, and no request is accepted until it ends (configuration writes are
// taken at all times). The result register lets the next word be accepted
// while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_2d_binning
    import hist2d_pkg::*;
#(
    parameter int MAX_BINS_X  = 64,
    parameter int MAX_BINS_Y  = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data,
    input  wire logic                   req_valid,
    output logic                        req_ready,
    input  wire hist2d_req_t            req,
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    output hist2d_rsp_t                 rsp
);
    localparam int NB = MAX_BINS_X * MAX_BINS_Y;
    localparam int AW = (NB > 1) ? $clog2(NB) : 1;

    hist2d_cmd_t            cmd;
    hist2d_stat_t           stat;
    logic                   mem_we;
    logic [AW-1:0]          mem_addr;
    logic [COUNT_WIDTH-1:0] mem_wdata, mem_rdata;

    // Always writable; user changes configuration only while idle (unchecked).
    assign cfg_ready = 1'b1;

    hist2d_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    hist2d_dp #(
        .MAX_BINS_X  (MAX_BINS_X),
        .MAX_BINS_Y  (MAX_BINS_Y),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Bin counters, addressed x index * MAX_BINS_Y + y index.
    hist2d_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NB)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

@@ src/hist2d_ram.sv @@
// ----------------------------------------------------------------------------
// hist2d_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hist2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [AW-1:0]            addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ src/hist2d_div.sv @@
// ----------------------------------------------------------------------------
// hist2d_div
// Restoring divider, one quotient bit per cycle, shared by the bin index and
// fraction calculations.
// ----------------------------------------------------------------------------
`default_nettype none

module hist2d_div #(
    parameter int DW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] rem_init,
    input  wire logic [DW-1:0] divisor,
    input  wire logic [31:0]   feed,
    input  wire logic [5:0]    steps,
    output logic               done,
    output logic [31:0]        quot
);
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] div_reg;
    logic [31:0]   feed_reg;
    logic [31:0]   quot_reg;
    logic [5:0]    cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic          fits;

    assign trial    = {rem_reg, feed_reg[31]};
    assign fits     = trial >= {1'b0, div_reg};
    assign rem_next = fits ? DW'(trial - {1'b0, div_reg}) : DW'(trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= rem_init;
            div_reg  <= divisor;
            feed_reg <= feed;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            feed_reg <= {feed_reg[30:0], 1'b0};
            quot_reg <= {quot_reg[30:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

@@ src/hist2d_dp.sv @@
// ----------------------------------------------------------------------------
// hist2d_dp
// Datapath: configuration registers, item registers, bin index arithmetic,
// counter update, fraction and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hist2d_dp
    import hist2d_pkg::*;
#(
    parameter int MAX_BINS_X  = 64,
    parameter int MAX_BINS_Y  = 64,
    parameter int COUNT_WIDTH = 32,
    localparam int NB = MAX_BINS_X * MAX_BINS_Y,
    localparam int AW = (NB > 1) ? $clog2(NB) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]            cfg_data,
    input  wire hist2d_req_t            req,
    input  wire hist2d_cmd_t            cmd,
    output hist2d_stat_t                stat,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_addr,
    output logic [COUNT_WIDTH-1:0]      mem_wdata,
    input  wire logic [COUNT_WIDTH-1:0] mem_rdata,
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    output hist2d_rsp_t                 rsp
);
    localparam int CW = COUNT_WIDTH;
    localparam int DW = (CW > 32) ? CW : 32;
    localparam logic [CW-1:0] CNT_MAX = '1;

    logic signed [31:0] x_lower_reg, x_upper_reg, y_lower_reg, y_upper_reg;
    logic [BIN_W-1:0]   bins_x_reg, bins_y_reg;
    hist2d_req_t        item_reg;
    logic [CW-1:0]      total_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_inc;
    logic [PROD_W-1:0]  prod_reg;
    logic [BIN_W-1:0]   ix_reg, iy_reg;
    logic [AW-1:0]      sweep_reg;
    hist2d_rsp_t        rsp_reg;
    logic               rsp_valid_reg;

    logic [31:0]        dx, dy, span_x, span_y;
    logic               div_start, div_done;
    logic [DW-1:0]      div_rem, div_divisor;
    logic [31:0]        div_feed, div_quot, frac;
    logic [5:0]         div_steps;
    logic [AW-1:0]      bin_addr;

    function automatic logic [31:0] show32(input logic [CW-1:0] v);
        return (DW'(v) > DW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(v);
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_lower_reg <= 32'sd0;
            x_upper_reg <= 32'sd65536;
            y_lower_reg <= 32'sd0;
            y_upper_reg <= 32'sd65536;
            bins_x_reg  <= 7'd64;
            bins_y_reg  <= 7'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_X_LOWER: x_lower_reg <= cfg_data;
                REG_X_UPPER: x_upper_reg <= cfg_data;
                REG_Y_LOWER: y_lower_reg <= cfg_data;
                REG_Y_UPPER: y_upper_reg <= cfg_data;
                REG_BINS_X:  bins_x_reg  <= cfg_data[BIN_W-1:0];
                REG_BINS_Y:  bins_y_reg  <= cfg_data[BIN_W-1:0];
                default:     ;
            endcase
        end
    end

    assign stat.op       = item_reg.opcode;
    assign stat.cfg_ok   = (x_lower_reg < x_upper_reg) && (y_lower_reg < y_upper_reg)
                         && (bins_x_reg != '0) && (32'(bins_x_reg) <= 32'(MAX_BINS_X))
                         && (bins_y_reg != '0) && (32'(bins_y_reg) <= 32'(MAX_BINS_Y));
    assign stat.in_range = (item_reg.sample_x > x_lower_reg) && (item_reg.sample_x < x_upper_reg)
                         && (item_reg.sample_y > y_lower_reg) && (item_reg.sample_y < y_upper_reg);
    assign stat.idx_ok   = ({1'b0, item_reg.read_bin_x} < bins_x_reg)
                         && ({1'b0, item_reg.read_bin_y} < bins_y_reg);
    assign stat.sweep_last = sweep_reg == AW'(NB - 1);
    assign stat.div_done   = div_done;
    assign stat.rsp_free   = !rsp_valid_reg || rsp_ready;

    // Offsets from the lower bound; the sample lies strictly inside, so
    // they are non-negative and below the span.
    assign dx     = 32'({item_reg.sample_x[31], item_reg.sample_x}
                        - {x_lower_reg[31], x_lower_reg});
    assign dy     = 32'({item_reg.sample_y[31], item_reg.sample_y}
                        - {y_lower_reg[31], y_lower_reg});
    assign span_x = 32'({x_upper_reg[31], x_upper_reg} - {x_lower_reg[31], x_lower_reg});
    assign span_y = 32'({y_upper_reg[31], y_upper_reg} - {y_lower_reg[31], y_lower_reg});

    // Item registers and arithmetic state.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= req;
        end
        if (cmd.mul_x)
        begin
            prod_reg <= PROD_W'(dx) * PROD_W'(bins_x_reg);
        end
        else if (cmd.mul_y)
        begin
            prod_reg <= PROD_W'(dy) * PROD_W'(bins_y_reg);
        end
        if (cmd.take_ix)
        begin
            ix_reg <= div_quot[BIN_W-1:0];
        end
        else if (cmd.take_ridx)
        begin
            ix_reg <= {1'b0, item_reg.read_bin_x};
        end
        if (cmd.take_iy)
        begin
            iy_reg <= div_quot[BIN_W-1:0];
        end
        else if (cmd.take_ridx)
        begin
            iy_reg <= {1'b0, item_reg.read_bin_y};
        end
        if (cmd.take_count)
        begin
            cnt_reg <= mem_rdata;
        end
        else if (cmd.write_inc)
        begin
            cnt_reg <= cnt_inc;
        end
        if (cmd.load_result)
        begin
            rsp_reg.status       <= cmd.res_status;
            rsp_reg.bin_count    <= cmd.show_count ? show32(cnt_reg) : 32'd0;
            rsp_reg.sample_total <= cmd.show_total ? show32(total_reg) : 32'd0;
            rsp_reg.bin_fraction <= cmd.show_count ? frac : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            sweep_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_total)
            begin
                total_reg <= '0;
            end
            else if (cmd.inc_total && total_reg != CNT_MAX)
            begin
                total_reg <= total_reg + CW'(1);
            end
            if (cmd.sweep_start)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.sweep_step)
            begin
                sweep_reg <= sweep_reg + AW'(1);
            end
            if (cmd.load_result)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign cnt_inc  = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + CW'(1);
    assign bin_addr = AW'(32'(ix_reg) * MAX_BINS_Y + 32'(iy_reg));

    assign mem_we    = cmd.sweep_step || cmd.write_inc;
    assign mem_addr  = cmd.sweep_step ? sweep_reg : bin_addr;
    assign mem_wdata = cmd.sweep_step ? '0 : cnt_inc;

    // Divider operands: bin index is (offset * bins) / span with seven
    // quotient bits; the fraction is (count * 2^31) / total with 32 bits.
    assign div_start   = cmd.go_x || cmd.go_y || cmd.go_frac;
    assign div_rem     = cmd.go_frac ? DW'(cnt_reg >> 1) : DW'(prod_reg[PROD_W-1:BIN_W]);
    assign div_divisor = cmd.go_frac ? DW'(total_reg) : (cmd.go_y ? DW'(span_y) : DW'(span_x));
    assign div_feed    = cmd.go_frac ? {cnt_reg[0], 31'd0} : {prod_reg[BIN_W-1:0], 25'd0};
    assign div_steps   = cmd.go_frac ? 6'd32 : 6'(BIN_W);

    hist2d_div #(
        .DW(DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem),
        .divisor  (div_divisor),
        .feed     (div_feed),
        .steps    (div_steps),
        .done     (div_done),
        .quot     (div_quot)
    );

    assign frac = (total_reg == '0)    ? 32'd0 :
                  (cnt_reg > total_reg) ? 32'h8000_0000 : div_quot;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

@@ src/hist2d_ctrl.sv @@
// ----------------------------------------------------------------------------
// hist2d_ctrl
// Sequencer for one word at a time: decode, clearing sweeps, divider runs,
// counter update and result hand-over.
// ----------------------------------------------------------------------------
`default_nettype none

module hist2d_ctrl
    import hist2d_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    output logic              req_ready,
    input  wire hist2d_stat_t stat,
    output hist2d_cmd_t       cmd
);
    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_CLR  = 4'd3;
    localparam logic [3:0] S_GOX  = 4'd4;
    localparam logic [3:0] S_DIVX = 4'd5;
    localparam logic [3:0] S_GOY  = 4'd6;
    localparam logic [3:0] S_DIVY = 4'd7;
    localparam logic [3:0] S_RD   = 4'd8;
    localparam logic [3:0] S_RDW  = 4'd9;
    localparam logic [3:0] S_UPD  = 4'd10;
    localparam logic [3:0] S_GOF  = 4'd11;
    localparam logic [3:0] S_FRAC = 4'd12;
    localparam logic [3:0] S_FIN  = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [1:0] res_status_reg, res_status_next;
    logic       show_total_reg, show_total_next;
    logic       show_count_reg, show_count_next;

    always_comb
    begin
        cmd             = '0;
        state_next      = state_reg;
        res_status_next = res_status_reg;
        show_total_next = show_total_reg;
        show_count_next = show_count_reg;
        cmd.res_status  = res_status_reg;
        cmd.show_total  = show_total_reg;
        cmd.show_count  = show_count_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DEC;
                end
            end
            S_DEC:
            begin
                res_status_next = ST_OK;
                show_total_next = 1'b0;
                show_count_next = 1'b0;
                state_next      = S_FIN;
                unique case (stat.op)
                    OP_CLEAR:
                    begin
                        cmd.sweep_start = 1'b1;
                        cmd.clr_total   = 1'b1;
                        state_next      = S_CLR;
                    end
                    OP_ADD:
                    begin
                        if (!stat.cfg_ok)
                        begin
                            res_status_next = ST_BAD_CFG;
                        end
                        else
                        begin
                            cmd.inc_total   = 1'b1;
                            show_total_next = 1'b1;
                            if (!stat.in_range)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                cmd.mul_x       = 1'b1;
                                show_count_next = 1'b1;
                                state_next      = S_GOX;
                            end
                        end
                    end
                    OP_READ:
                    begin
                        show_total_next = 1'b1;
                        if (!stat.cfg_ok)
                        begin
                            res_status_next = ST_BAD_CFG;
                        end
                        else if (!stat.idx_ok)
                        begin
                            res_status_next = ST_BAD_IDX;
                        end
                        else
                        begin
                            cmd.take_ridx   = 1'b1;
                            show_count_next = 1'b1;
                            state_next      = S_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_CLR:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_GOX:
            begin
                cmd.go_x   = 1'b1;
                state_next = S_DIVX;
            end
            S_DIVX:
            begin
                if (stat.div_done)
                begin
                    cmd.take_ix = 1'b1;
                    cmd.mul_y   = 1'b1;
                    state_next  = S_GOY;
                end
            end
            S_GOY:
            begin
                cmd.go_y   = 1'b1;
                state_next = S_DIVY;
            end
            S_DIVY:
            begin
                if (stat.div_done)
                begin
                    cmd.take_iy = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_RDW;
            end
            S_RDW:
            begin
                cmd.take_count = 1'b1;
                state_next     = (stat.op == OP_ADD) ? S_UPD : S_GOF;
            end
            S_UPD:
            begin
                cmd.write_inc = 1'b1;
                state_next    = S_GOF;
            end
            S_GOF:
            begin
                cmd.go_frac = 1'b1;
                state_next  = S_FRAC;
            end
            S_FRAC:
            begin
                if (stat.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (stat.rsp_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            res_status_reg <= ST_OK;
            show_total_reg <= 1'b0;
            show_count_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            show_total_reg <= show_total_next;
            show_count_reg <= show_count_next;
        end
    end

    assign req_ready = state_reg == S_IDLE;

endmodule

`default_nettype wire

@@ src/hist2d_checker.sv @@
// ----------------------------------------------------------------------------
// hist2d_checker
// Port-level checks on the histogram block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "histogram_2d_binning_assert.svh"

module hist2d_checker
    import hist2d_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire hist2d_rsp_t rsp
);
    // A waiting result holds still.
    `H2D_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
    // Words are processed one at a time.
    `H2D_ASSERT_NEXT(a_one_word, req_valid && req_ready, !req_ready)
    // Error and out-of-range results carry no count or fraction.
    `H2D_ASSERT_SAME(a_err_zero, rsp_valid && (rsp.status == ST_RANGE || rsp.status == ST_BAD_CFG || rsp.status == ST_BAD_IDX), rsp.bin_count == 32'd0 && rsp.bin_fraction == 32'd0)
    // A fraction never exceeds one.
    `H2D_ASSERT_SAME(a_frac_max, rsp_valid && rsp.bin_fraction[31], rsp.bin_fraction[30:0] == 31'd0)

endmodule

bind histogram_2d_binning hist2d_checker u_checker (.*);

`default_nettype wire
